FILE: hw/rtl/kpm_pkg.sv
// Shared types, key map and display constants for the keypad menu controller.
package kpm_pkg;

  localparam int KeyW    = 5;
  localparam int MenuW   = 3;
  localparam int LedW    = 8;
  localparam int CountW  = 8;
  localparam int MatrixW = 16;
  localparam int OutW    = 32;

  localparam logic [KeyW-1:0] NO_KEY    = 5'd16;
  localparam logic [KeyW-1:0] KEY_CLEAR = 5'd14;
  localparam logic [KeyW-1:0] KEY_RUN   = 5'd15;

  localparam logic [CountW-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [CountW-1:0] PERIOD_RST   = 8'd200;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_PERIOD   = 2'd1;

  // item kinds carried in tuser
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  // menu codes
  localparam logic [MenuW-1:0] MENU_NONE  = 3'd0;
  localparam logic [MenuW-1:0] MENU_BLINK = 3'd1;
  localparam logic [MenuW-1:0] MENU_COUNT = 3'd2;
  localparam logic [MenuW-1:0] MENU_RING  = 3'd3;
  localparam logic [MenuW-1:0] MENU_TOGGLE = 3'd4;

  typedef struct packed {
    logic            accepted;
    logic [KeyW-1:0] code;
  } kpm_key_evt_t;

  typedef struct packed {
    logic [LedW-1:0]  led;
    logic [MenuW-1:0] menu;
    logic             run;
  } kpm_menu_stat_t;

  // Key code at each matrix position, row by row
  function automatic logic [KeyW-1:0] key_at(input logic [3:0] pos);
    logic [KeyW-1:0] k;
    case (pos)
      4'd0:    k = 5'd7;
      4'd1:    k = 5'd8;
      4'd2:    k = 5'd9;
      4'd3:    k = 5'd10;
      4'd4:    k = 5'd4;
      4'd5:    k = 5'd5;
      4'd6:    k = 5'd6;
      4'd7:    k = 5'd11;
      4'd8:    k = 5'd1;
      4'd9:    k = 5'd2;
      4'd10:   k = 5'd3;
      4'd11:   k = 5'd12;
      4'd12:   k = 5'd14;
      4'd13:   k = 5'd0;
      4'd14:   k = 5'd15;
      default: k = 5'd13;
    endcase
    return k;
  endfunction

  // Highest pressed position wins
  function automatic logic [KeyW-1:0] decode_matrix(input logic [MatrixW-1:0] m);
    logic [KeyW-1:0] k;
    k = NO_KEY;
    for (int p = 0; p < MatrixW; p++) begin
      if (m[p]) k = key_at(4'(p));
    end
    return k;
  endfunction

  // Common-anode seven-segment digits 0..7
  function automatic logic [7:0] seg_code(input logic [MenuW-1:0] d);
    logic [7:0] s;
    case (d)
      3'd0:    s = 8'hC0;
      3'd1:    s = 8'hF9;
      3'd2:    s = 8'hA4;
      3'd3:    s = 8'hB0;
      3'd4:    s = 8'h99;
      3'd5:    s = 8'h92;
      3'd6:    s = 8'h82;
      default: s = 8'hF8;
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/kpm_key_scan.sv
// Matrix decode and debounce with auto-repeat while a key is held.
module kpm_key_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         scan,
  input  logic [kpm_pkg::MatrixW-1:0]  key_matrix,
  input  logic [kpm_pkg::CountW-1:0]   debounce_count,
  output kpm_pkg::kpm_key_evt_t        evt
);

  logic [kpm_pkg::KeyW-1:0]   last_key_r, last_key_nxt;
  logic [kpm_pkg::CountW-1:0] stable_r, stable_nxt;
  logic [kpm_pkg::CountW-1:0] stable_inc;
  logic [kpm_pkg::KeyW-1:0]   code;
  logic                       acc;

  // decode and count equal scans
  always_comb begin
    code         = scan ? kpm_pkg::decode_matrix(key_matrix) : kpm_pkg::NO_KEY;
    stable_inc   = stable_r + 8'd1;
    last_key_nxt = last_key_r;
    stable_nxt   = stable_r;
    acc          = 1'b0;
    if (scan) begin
      if (code != last_key_r) begin
        last_key_nxt = code;
        stable_nxt   = '0;
      end else if (code != kpm_pkg::NO_KEY) begin
        if (stable_inc == debounce_count) begin
          stable_nxt = '0;
          acc        = 1'b1;
        end else begin
          stable_nxt = stable_inc;
        end
      end else begin
        stable_nxt = '0;
      end
    end
    evt.accepted = acc;
    evt.code     = code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_key_r <= '0;
      stable_r   <= '0;
    end else if (step) begin
      last_key_r <= last_key_nxt;
      stable_r   <= stable_nxt;
    end
  end

endmodule

FILE: hw/rtl/kpm_menu_ctrl.sv
// Menu selection, run control, tick counter and LED pattern stepping.
module kpm_menu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        scan,
  input  kpm_pkg::kpm_key_evt_t       evt,
  input  logic [kpm_pkg::CountW-1:0]  pattern_period,
  output kpm_pkg::kpm_menu_stat_t     stat
);

  logic [kpm_pkg::MenuW-1:0]  menu_r, menu_nxt;
  logic                       run_r, run_nxt;
  logic [kpm_pkg::CountW-1:0] idx_r, idx_nxt;
  logic [kpm_pkg::CountW-1:0] tick_r, tick_nxt;
  logic [kpm_pkg::LedW-1:0]   led_r, led_nxt;
  logic [kpm_pkg::CountW-1:0] idx_inc;
  logic [kpm_pkg::LedW-1:0]   ring_bit;

  always_comb begin
    menu_nxt = menu_r;
    run_nxt  = run_r;
    idx_nxt  = idx_r;
    tick_nxt = tick_r;
    led_nxt  = led_r;

    // key handling on scans, counter advance on ticks
    if (scan) begin
      if (evt.accepted) begin
        if (evt.code >= 5'd1 && evt.code <= 5'd4) begin
          if (!run_r) menu_nxt = evt.code[kpm_pkg::MenuW-1:0];
        end else if (evt.code == kpm_pkg::KEY_CLEAR) begin
          if (!run_r) menu_nxt = kpm_pkg::MENU_NONE;
        end else if (evt.code == kpm_pkg::KEY_RUN) begin
          if (menu_r != kpm_pkg::MENU_NONE) begin
            run_nxt = !run_r;
            if (run_r) begin
              led_nxt  = '0;
              idx_nxt  = '0;
              tick_nxt = '0;
            end
          end
        end
      end
    end else begin
      tick_nxt = tick_r + 8'd1;
    end

    // pattern step when the period is reached
    idx_inc  = idx_nxt + 8'd1;
    ring_bit = (idx_nxt < 8'd8) ? (8'd1 << idx_nxt[2:0]) : 8'd0;
    if (run_nxt && tick_nxt == pattern_period) begin
      tick_nxt = '0;
      case (menu_nxt)
        kpm_pkg::MENU_BLINK: led_nxt = ~led_nxt;
        kpm_pkg::MENU_COUNT: begin
          idx_nxt = idx_inc;
          led_nxt = idx_inc;
        end
        kpm_pkg::MENU_RING: begin
          led_nxt = ring_bit;
          idx_nxt = (idx_inc >= 8'd8) ? 8'd0 : idx_inc;
        end
        kpm_pkg::MENU_TOGGLE: begin
          led_nxt = led_nxt ^ ring_bit;
          idx_nxt = (idx_inc >= 8'd8) ? 8'd0 : idx_inc;
        end
        default: ;
      endcase
    end

    stat.led  = led_nxt;
    stat.menu = menu_nxt;
    stat.run  = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      menu_r <= '0;
      run_r  <= 1'b0;
      idx_r  <= '0;
      tick_r <= '0;
      led_r  <= '0;
    end else if (step) begin
      menu_r <= menu_nxt;
      run_r  <= run_nxt;
      idx_r  <= idx_nxt;
      tick_r <= tick_nxt;
      led_r  <= led_nxt;
    end
  end

endmodule

FILE: hw/rtl/keypad_menu_led_pattern_controller_unit.sv
// Top level of the keypad menu controller: input stage, update logic, result register.
// Each request is a keypad scan (in_tuser = 1) or a timer tick (in_tuser = 0) and
// produces exactly one result. A request is registered on entry, updated against the
// controller state when the result register is free or being drained, and lands in the
// result register; one request is taken every cycle as long as results are taken.
// Throughput is set by the state update in the menu controller.
// Configuration writes (index 0 debounce count, 1 pattern period) are always accepted
// and must only be issued while no request is in flight.
module keypad_menu_led_pattern_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] key_matrix
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] led_pattern, [15:8] segment_code, [18:16] menu_number, [19] running,
  // [20] key_accepted, [25:21] key_code, [31:26] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        in_vld_r;
  logic [15:0] in_mat_r;
  logic        in_act_r;
  logic        advance;
  logic        scan;
  logic [7:0]  debounce_r;
  logic [7:0]  period_r;
  logic [31:0] out_data_r;
  logic        out_vld_r;

  kpm_pkg::kpm_key_evt_t   evt;
  kpm_pkg::kpm_menu_stat_t stat;

  // handshake: the stage moves when the result register is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign scan      = (in_act_r == kpm_pkg::ACT_SCAN);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kpm_pkg::DEBOUNCE_RST;
      period_r   <= kpm_pkg::PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kpm_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data;
        kpm_pkg::CFG_PERIOD:   period_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mat_r <= in_tdata;
      in_act_r <= in_tuser;
    end
  end

  kpm_key_scan u_key_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .scan           (scan),
    .key_matrix     (in_mat_r),
    .debounce_count (debounce_r),
    .evt            (evt)
  );

  kpm_menu_ctrl u_menu_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .scan           (scan),
    .evt            (evt),
    .pattern_period (period_r),
    .stat           (stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'd0, evt.code, evt.accepted, stat.run, stat.menu,
                     kpm_pkg::seg_code(stat.menu), stat.led};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/kpm_checker.sv
// Port-level checks for the keypad menu controller, bound to the top level.
module kpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted key is always a real key
  a_acc_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> out_tdata[25:21] != kpm_pkg::NO_KEY)
    else $error("accepted key without a key code");

  // running needs a selected menu
  a_run_menu: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[18:16] != kpm_pkg::MENU_NONE)
    else $error("running with no menu selected");

  // the digit follows the menu
  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:8] == kpm_pkg::seg_code(out_tdata[18:16]))
    else $error("segment code does not match menu");

endmodule

bind keypad_menu_led_pattern_controller_unit kpm_checker u_kpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/keypad_menu_led_pattern_controller_unit_test.sv
// Self-checking testbench for the keypad menu LED pattern controller.
`timescale 1ns / 1ps

module keypad_menu_led_pattern_controller_unit_test;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int PHASE_ITEMS    = 170;
  localparam int MAX_GAP        = 17;
  localparam int PRINT_LIMIT    = 50;

  // key code at each matrix position, row by row
  localparam logic [4:0] KEY_BY_POS [16] = '{
    5'd7, 5'd8, 5'd9, 5'd10, 5'd4, 5'd5, 5'd6, 5'd11,
    5'd1, 5'd2, 5'd3, 5'd12, 5'd14, 5'd0, 5'd15, 5'd13
  };
  // common-anode digit codes
  localparam logic [7:0] SEG_BY_DIGIT [8] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8
  };
  // register settings per random session, extremes included
  localparam logic [7:0] DEBOUNCE_PLAN [8] = '{
    8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'd2, 8'd1, 8'd4
  };
  localparam logic [7:0] PERIOD_PLAN [8] = '{
    8'd1, 8'd3, 8'd255, 8'd2, 8'd5, 8'd0, 8'd7, 8'd1
  };

  // result word, same layout as out_tdata
  typedef struct packed {
    logic [5:0] pad;
    logic [4:0] code;
    logic       accepted;
    logic       run;
    logic [2:0] menu;
    logic [7:0] seg;
    logic [7:0] led;
  } display_status_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] key_matrix
  logic        in_tuser;   // [0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // led, segment, menu, running, accepted, key code
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  // controller state as predicted
  logic [4:0] last_key_m;
  logic [7:0] stable_m;
  logic [2:0] menu_m;
  logic       run_m;
  logic [7:0] index_m;
  logic [7:0] ticks_m;
  logic [7:0] leds_m;
  logic [7:0] debounce_m;
  logic [7:0] period_m;

  display_status_t pending_status_q [$];
  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  sent_count     = 0;
  int  idle_cycles    = 0;
  bit  in_steady      = 1'b0;
  bit  out_steady     = 1'b0;

  keypad_menu_led_pattern_controller_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one request to the predicted state and return the status it yields
  function automatic display_status_t next_display_status(input logic act,
                                                          input logic [15:0] m);
    display_status_t r;
    logic [4:0] code;
    logic       acc;
    logic [7:0] one_hot;
    code = kpm_pkg::NO_KEY;
    acc  = 1'b0;
    if (act == kpm_pkg::ACT_SCAN) begin
      for (int p = 0; p < 16; p++) begin
        if (m[p]) code = KEY_BY_POS[p];
      end
      if (code != last_key_m) begin
        last_key_m = code;
        stable_m   = '0;
      end else if (code != kpm_pkg::NO_KEY) begin
        stable_m = stable_m + 8'd1;
        if (stable_m == debounce_m) begin
          stable_m = '0;
          acc      = 1'b1;
        end
      end else begin
        stable_m = '0;
      end
      // key action
      if (acc) begin
        if (code >= 5'(kpm_pkg::MENU_BLINK) && code <= 5'(kpm_pkg::MENU_TOGGLE)) begin
          if (!run_m) menu_m = code[2:0];
        end else if (code == kpm_pkg::KEY_CLEAR) begin
          if (!run_m) menu_m = kpm_pkg::MENU_NONE;
        end else if (code == kpm_pkg::KEY_RUN && menu_m != kpm_pkg::MENU_NONE) begin
          run_m = !run_m;
          if (!run_m) begin
            leds_m  = '0;
            index_m = '0;
            ticks_m = '0;
          end
        end
      end
    end else begin
      ticks_m = ticks_m + 8'd1;
    end
    // pattern step at the period
    if (run_m && ticks_m == period_m) begin
      ticks_m = '0;
      one_hot = (index_m < 8) ? (8'd1 << index_m) : 8'd0;
      case (menu_m)
        kpm_pkg::MENU_BLINK: leds_m = ~leds_m;
        kpm_pkg::MENU_COUNT: begin
          index_m = index_m + 8'd1;
          leds_m  = index_m;
        end
        kpm_pkg::MENU_RING, kpm_pkg::MENU_TOGGLE: begin
          leds_m  = (menu_m == kpm_pkg::MENU_RING) ? one_hot : (leds_m ^ one_hot);
          index_m = (index_m + 8'd1 >= 8) ? 8'd0 : index_m + 8'd1;
        end
        default: ;
      endcase
    end
    r.pad      = '0;
    r.code     = code;
    r.accepted = acc;
    r.run      = run_m;
    r.menu     = menu_m;
    r.seg      = SEG_BY_DIGIT[menu_m];
    r.led      = leds_m;
    return r;
  endfunction

  // matrix position of a key code
  function automatic logic [3:0] pos_of(input logic [4:0] k);
    logic [3:0] pos;
    pos = '0;
    for (int p = 0; p < 16; p++) begin
      if (KEY_BY_POS[p] == k) pos = 4'(p);
    end
    return pos;
  endfunction

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
               $realtime, results_seen, what, got, want);
  endtask

  // send one request, then record what it should produce
  task automatic send_request(input logic act, input logic [15:0] m);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = draw_gap(in_steady);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= m;
    do @(posedge clk); while (!in_tready);
    pending_status_q.push_back(next_display_status(act, m));
    sent_count++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == kpm_pkg::CFG_DEBOUNCE) debounce_m = value;
    else if (idx == kpm_pkg::CFG_PERIOD) period_m = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold a key for a number of scans, lower positions pressed at random too
  task automatic hold_key(input logic [3:0] pos, input int scans);
    logic [15:0] m;
    for (int i = 0; i < scans; i++) begin
      if ($urandom_range(0, 5) == 0) send_request(kpm_pkg::ACT_TICK, 16'($urandom));
      m = (16'd1 << pos) | (16'($urandom) & ((16'd1 << pos) - 16'd1));
      send_request(kpm_pkg::ACT_SCAN, m);
    end
  endtask

  // defaults after reset
  task automatic test_reset_state();
    send_request(kpm_pkg::ACT_SCAN, 16'h0000);
    send_request(kpm_pkg::ACT_TICK, 16'hFFFF);
  endtask

  // every key action with fast debounce and period
  task automatic test_key_actions();
    write_register(kpm_pkg::CFG_DEBOUNCE, 8'd1);
    write_register(kpm_pkg::CFG_PERIOD, 8'd1);
    // all pressed
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'hFFFF);
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(5'(kpm_pkg::MENU_BLINK)));
    // start
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(kpm_pkg::KEY_RUN));
    // blink steps
    repeat (2) send_request(kpm_pkg::ACT_TICK, 16'h0000);
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(5'(kpm_pkg::MENU_COUNT)));
    // ignored while running
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(kpm_pkg::KEY_CLEAR));
    // stop clears
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(kpm_pkg::KEY_RUN));
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(kpm_pkg::KEY_CLEAR));
    // no menu, no run
    repeat (2) send_request(kpm_pkg::ACT_SCAN, 16'd1 << pos_of(kpm_pkg::KEY_RUN));
  endtask

  // random key sessions under several register settings
  task automatic test_random_sessions();
    int  start;
    int  pick;
    int  eff_debounce;
    int  eff_period;
    int  hold;
    bit  paused;
    logic [7:0] period_set;
    for (int ph = 0; ph < 8; ph++) begin
      period_set = (ph == 6) ? 8'($urandom_range(4, 40)) : PERIOD_PLAN[ph];
      write_register(kpm_pkg::CFG_DEBOUNCE, DEBOUNCE_PLAN[ph]);
      write_register(kpm_pkg::CFG_PERIOD, period_set);
      start  = sent_count;
      paused = 1'b0;
      while (sent_count - start < PHASE_ITEMS) begin
        eff_debounce = (debounce_m == 0) ? 256 : int'(debounce_m);
        eff_period   = (period_m == 0) ? 256 : int'(period_m);
        hold = eff_debounce + 1 + int'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 30)
          hold_key(pos_of(5'($urandom_range(1, 4))), hold);
        else if (pick < 50)
          hold_key(pos_of(kpm_pkg::KEY_RUN), hold);
        else if (pick < 57)
          hold_key(pos_of(kpm_pkg::KEY_CLEAR), hold);
        else if (pick < 65)
          hold_key(4'($urandom_range(0, 15)), $urandom_range(1, hold));
        else if (pick < 85)
          repeat ($urandom_range(1, eff_period))
            send_request(kpm_pkg::ACT_TICK, 16'($urandom));
        else
          repeat ($urandom_range(1, 4)) send_request(kpm_pkg::ACT_SCAN, 16'($urandom));
        // release now and then
        if ($urandom_range(0, 1) == 0) send_request(kpm_pkg::ACT_SCAN, 16'h0000);
        // hold off until everything is back once per session
        if (!paused && sent_count - start >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
  endtask

  // result receiver and checker
  initial begin
    display_status_t got;
    display_status_t want;
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = draw_gap(out_steady);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = display_status_t'(out_tdata);
      results_seen++;
      if (pending_status_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(got), 0);
      end else begin
        want = pending_status_q.pop_front();
        if (got.led != want.led)
          report_mismatch("led_pattern", int'(got.led), int'(want.led));
        if (got.seg != want.seg)
          report_mismatch("segment_code", int'(got.seg), int'(want.seg));
        if (got.menu != want.menu)
          report_mismatch("menu_number", int'(got.menu), int'(want.menu));
        if (got.run != want.run)
          report_mismatch("running", int'(got.run), int'(want.run));
        if (got.accepted != want.accepted)
          report_mismatch("key_accepted", int'(got.accepted), int'(want.accepted));
        if (got.code != want.code)
          report_mismatch("key_code", int'(got.code), int'(want.code));
        if (got.pad != want.pad)
          report_mismatch("unused bits", int'(got.pad), int'(want.pad));
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sequence of tests
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= kpm_pkg::ACT_TICK;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= kpm_pkg::CFG_DEBOUNCE;
    cfg_data   <= '0;
    debounce_m = kpm_pkg::DEBOUNCE_RST;
    period_m   = kpm_pkg::PERIOD_RST;
    last_key_m = '0;
    stable_m   = '0;
    menu_m     = kpm_pkg::MENU_NONE;
    run_m      = 1'b0;
    index_m    = '0;
    ticks_m    = '0;
    leds_m     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_key_actions();
    test_random_sessions();
    wait_drained();
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
